// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker module fon_checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while rst is high.
`define FON_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, masked while rst is high.
`define FON_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== rtl/core/fon_pkg.sv =====
`timescale 1ns / 1ps

package fon_pkg;

   localparam int UNIT_W = 32;
   localparam int CSR_W  = 16;
   localparam int RES_W  = 35;

   localparam logic [UNIT_W-1:0] ONE_Q30         = 32'h4000_0000;
   localparam logic [UNIT_W-1:0] NINE_TENTHS_Q30 = 32'd966367642;

   // Shift right by 30, rounding half away from zero.
   function automatic logic signed [37:0] rnd30(input logic signed [67:0] v);
      logic [67:0] m;
      logic [37:0] u;
      m = v[67] ? 68'(-v) : 68'(v);
      u = 38'((m + 68'd536870912) >> 30);
      return v[67] ? -$signed(u) : $signed(u);
   endfunction

endpackage

// ===== rtl/core/fon_norm.sv =====
`timescale 1ns / 1ps

module fon_norm #(
   parameter int VW = 48,
   parameter int SW = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 en,
   input  logic                                 in_valid,
   input  logic [2:0][VW-1:0]                   in_vec,
   input  logic [SW-1:0]                        in_side,
   output logic                                 out_valid,
   output logic [2:0][fon_pkg::UNIT_W-1:0]      out_vec,
   output logic [SW-1:0]                        out_side
);
   import fon_pkg::*;

   localparam int PW  = $clog2(VW);
   localparam int RB  = 31;
   localparam int LAT = 5 + 2 * RB + 1;

   logic [LAT-1:0]         v_ff;
   logic [LAT-1:0][SW-1:0] side_ff;

   logic [2:0][VW-1:0] st1_mag_in, st1_mag_ff;
   logic [2:0]         st1_neg_ff;
   logic [VW-1:0]      st1_or_ff;
   logic [2:0][VW-1:0] st2_mag_ff;
   logic [2:0]         st2_neg_ff;
   logic [PW-1:0]      st2_pos_in, st2_pos_ff;
   logic               st2_zero_ff;
   logic [VW+28:0]     st3_wide [3];
   logic [2:0][29:0]   st3_m_in, st3_m_ff;
   logic [2:0]         st3_neg_ff;
   logic               st3_zero_ff;
   logic [2:0][59:0]   st4_sq_ff;
   logic [2:0][29:0]   st4_m_ff;
   logic [2:0]         st4_neg_ff;
   logic               st4_zero_ff;
   logic [61:0]        st5_s_ff;
   logic [2:0][29:0]   st5_m_ff;
   logic [2:0]         st5_neg_ff;
   logic               st5_zero_ff;

   logic [32:0]        sq_rem_ff  [RB];
   logic [RB-1:0]      sq_root_ff [RB];
   logic [61:0]        sq_s_ff    [RB];
   logic [2:0][29:0]   sq_m_ff    [RB];
   logic [2:0]         sq_neg_ff  [RB];
   logic               sq_zero_ff [RB];

   logic [2:0][31:0]   dv_rem_ff  [RB];
   logic [2:0][RB-1:0] dv_q_ff    [RB];
   logic [RB-1:0]      dv_r_ff    [RB];
   logic [2:0]         dv_neg_ff  [RB];
   logic               dv_zero_ff [RB];

   logic [2:0][UNIT_W-1:0] out_vec_in, out_vec_ff;
   logic [UNIT_W-1:0]      qv [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[LAT-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff <= {side_ff[LAT-2:0], in_side};
      end
   end

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         st1_mag_in[c] = in_vec[c][VW-1] ? VW'(-in_vec[c]) : in_vec[c];
      end
      st2_pos_in = '0;
      for (int i = 0; i < VW; i++) begin
         if (st1_or_ff[i]) begin
            st2_pos_in = PW'(i);
         end
      end
      for (int c = 0; c < 3; c++) begin
         st3_wide[c] = {st2_mag_ff[c], 29'b0} >> st2_pos_ff;
         st3_m_in[c] = st3_wide[c][29:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         st1_mag_ff  <= st1_mag_in;
         st1_neg_ff  <= {in_vec[2][VW-1], in_vec[1][VW-1], in_vec[0][VW-1]};
         st1_or_ff   <= st1_mag_in[0] | st1_mag_in[1] | st1_mag_in[2];
         st2_mag_ff  <= st1_mag_ff;
         st2_neg_ff  <= st1_neg_ff;
         st2_pos_ff  <= st2_pos_in;
         st2_zero_ff <= (st1_or_ff == '0);
         st3_m_ff    <= st3_m_in;
         st3_neg_ff  <= st2_neg_ff;
         st3_zero_ff <= st2_zero_ff;
         for (int c = 0; c < 3; c++) begin
            st4_sq_ff[c] <= 60'(st3_m_ff[c]) * 60'(st3_m_ff[c]);
         end
         st4_m_ff    <= st3_m_ff;
         st4_neg_ff  <= st3_neg_ff;
         st4_zero_ff <= st3_zero_ff;
         st5_s_ff    <= 62'(st4_sq_ff[0]) + 62'(st4_sq_ff[1]) + 62'(st4_sq_ff[2]);
         st5_m_ff    <= st4_m_ff;
         st5_neg_ff  <= st4_neg_ff;
         st5_zero_ff <= st4_zero_ff;
      end
   end

   for (genvar g = 0; g < RB; g++) begin : g_sqrt
      logic [32:0]      p_rem;
      logic [RB-1:0]    p_root;
      logic [61:0]      p_s;
      logic [2:0][29:0] p_m;
      logic [2:0]       p_neg;
      logic             p_zero;
      logic [34:0]      rem2, trial;
      logic [32:0]      rem_in;
      logic [RB-1:0]    root_in;
      if (g == 0) begin : g_head
         assign p_rem  = '0;
         assign p_root = '0;
         assign p_s    = st5_s_ff;
         assign p_m    = st5_m_ff;
         assign p_neg  = st5_neg_ff;
         assign p_zero = st5_zero_ff;
      end else begin : g_tail
         assign p_rem  = sq_rem_ff[g-1];
         assign p_root = sq_root_ff[g-1];
         assign p_s    = sq_s_ff[g-1];
         assign p_m    = sq_m_ff[g-1];
         assign p_neg  = sq_neg_ff[g-1];
         assign p_zero = sq_zero_ff[g-1];
      end
      always_comb begin
         rem2  = {p_rem, p_s[61:60]};
         trial = {2'b00, p_root, 2'b01};
         if (rem2 >= trial) begin
            rem_in  = 33'(rem2 - trial);
            root_in = {p_root[RB-2:0], 1'b1};
         end else begin
            rem_in  = rem2[32:0];
            root_in = {p_root[RB-2:0], 1'b0};
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            sq_rem_ff[g]  <= rem_in;
            sq_root_ff[g] <= root_in;
            sq_s_ff[g]    <= {p_s[59:0], 2'b00};
            sq_m_ff[g]    <= p_m;
            sq_neg_ff[g]  <= p_neg;
            sq_zero_ff[g] <= p_zero;
         end
      end
   end

   for (genvar g = 0; g < RB; g++) begin : g_div
      logic [2:0][31:0]   p_rem;
      logic [2:0][RB-1:0] p_q;
      logic [RB-1:0]      p_r;
      logic [2:0]         p_neg;
      logic               p_zero;
      logic [32:0]        dvs;
      logic [2:0][32:0]   rem2;
      logic [2:0][31:0]   rem_in;
      logic [2:0][RB-1:0] q_in;
      if (g == 0) begin : g_head
         assign p_rem  = {{2'b00, sq_m_ff[RB-1][2]}, {2'b00, sq_m_ff[RB-1][1]},
                          {2'b00, sq_m_ff[RB-1][0]}};
         assign p_q    = '0;
         assign p_r    = sq_root_ff[RB-1];
         assign p_neg  = sq_neg_ff[RB-1];
         assign p_zero = sq_zero_ff[RB-1];
      end else begin : g_tail
         assign p_rem  = dv_rem_ff[g-1];
         assign p_q    = dv_q_ff[g-1];
         assign p_r    = dv_r_ff[g-1];
         assign p_neg  = dv_neg_ff[g-1];
         assign p_zero = dv_zero_ff[g-1];
      end
      always_comb begin
         dvs = {1'b0, p_r, 1'b0};
         for (int c = 0; c < 3; c++) begin
            rem2[c] = {p_rem[c], p_r[RB-1-g]};
            if (rem2[c] >= dvs) begin
               rem_in[c] = 32'(rem2[c] - dvs);
               q_in[c]   = {p_q[c][RB-2:0], 1'b1};
            end else begin
               rem_in[c] = rem2[c][31:0];
               q_in[c]   = {p_q[c][RB-2:0], 1'b0};
            end
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            dv_rem_ff[g]  <= rem_in;
            dv_q_ff[g]    <= q_in;
            dv_r_ff[g]    <= p_r;
            dv_neg_ff[g]  <= p_neg;
            dv_zero_ff[g] <= p_zero;
         end
      end
   end

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         qv[c]         = {1'b0, dv_q_ff[RB-1][c]};
         out_vec_in[c] = dv_neg_ff[RB-1][c] ? -qv[c] : qv[c];
      end
      if (dv_zero_ff[RB-1]) begin
         out_vec_in = {32'd0, 32'd0, ONE_Q30};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_vec_ff <= out_vec_in;
      end
   end

   assign out_valid = v_ff[LAT-1];
   assign out_side  = side_ff[LAT-1];
   assign out_vec   = out_vec_ff;

endmodule

// ===== rtl/core/fon_ortho.sv =====
`timescale 1ns / 1ps

module fon_ortho #(
   parameter int CW = 32,
   parameter int SW = 96
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 en,
   input  logic [fon_pkg::CSR_W-1:0]            zero_limit,
   input  logic                                 in_valid,
   input  logic [2:0][fon_pkg::UNIT_W-1:0]      in_x,
   input  logic [2:0][CW-1:0]                   in_b,
   input  logic [SW-1:0]                        in_side,
   output logic                                 out_valid,
   output logic [2:0][fon_pkg::RES_W-1:0]       out_vec,
   output logic [2:0][fon_pkg::UNIT_W-1:0]      out_x,
   output logic [SW-1:0]                        out_side
);
   import fon_pkg::*;

   localparam int BW  = (CW > 33) ? CW : 33;
   localparam int KB  = $clog2(BW);
   localparam int ZW  = RES_W + BW;
   localparam int XW  = 3 * UNIT_W;
   localparam int DW  = XW + SW;
   localparam int LAT = 11;

   logic [LAT-1:0]         v_ff;
   logic [LAT-1:0][DW-1:0] dl_ff;
   logic [2:0][UNIT_W-1:0] x4, x7, x10, x11;

   logic [BW-1:0]          ext [3];
   logic [2:0][BW-1:0]     o1_bm_in, o1_bm_ff, o2_bm_ff;
   logic [2:0]             o1_neg_ff, o2_neg_ff;
   logic [BW-1:0]          mx;
   logic [KB-1:0]          o2_k_in, o2_k_ff, o3_k_ff, o4_k_ff, o5_k_ff, o6_k_ff;
   logic [KB-1:0]          o7_k_ff, o8_k_ff, o9_k_ff;
   logic [BW-1:0]          bs [3];
   logic [32:0]            mag33 [3];
   logic [2:0][32:0]       o3_sb_in, o3_sb_ff, o4_sb_ff, o5_sb_ff, o6_sb_ff, o7_sb_ff, o8_sb_ff;
   logic [2:0][64:0]       o4_prod_ff;
   logic [66:0]            o5_dot_ff;
   logic [33:0]            o6_d_ff;
   logic [2:0][65:0]       o7_dx_ff;
   logic [2:0][33:0]       o8_rx_ff;
   logic [2:0][RES_W-1:0]  o9_res_ff, o10_res_ff, o11_vec_in, o11_vec_ff;
   logic [RES_W-1:0]       resmag [3];
   logic [ZW-1:0]          scaled [3];
   logic                   o10_small_in, o10_small_ff;
   logic [UNIT_W-1:0]      xzm;
   logic                   o10_nearz_ff;

   assign x4  = dl_ff[2][XW-1:0];
   assign x7  = dl_ff[5][XW-1:0];
   assign x10 = dl_ff[8][XW-1:0];
   assign x11 = dl_ff[9][XW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[LAT-2:0], in_valid};
      end
   end

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         ext[c]      = BW'($signed(in_b[c]));
         o1_bm_in[c] = ext[c][BW-1] ? BW'(-ext[c]) : ext[c];
      end
      mx = (o1_bm_ff[0] > o1_bm_ff[1]) ? o1_bm_ff[0] : o1_bm_ff[1];
      mx = (o1_bm_ff[2] > mx) ? o1_bm_ff[2] : mx;
      o2_k_in = '0;
      for (int kk = BW - 1; kk >= 0; kk--) begin
         if ((mx >> kk) <= (BW'(1) << 31)) begin
            o2_k_in = KB'(kk);
         end
      end
      for (int c = 0; c < 3; c++) begin
         bs[c]       = o2_bm_ff[c] >> o2_k_ff;
         mag33[c]    = {1'b0, bs[c][31:0]};
         o3_sb_in[c] = o2_neg_ff[c] ? -mag33[c] : mag33[c];
      end
      o10_small_in = 1'b1;
      for (int c = 0; c < 3; c++) begin
         resmag[c] = o9_res_ff[c][RES_W-1] ? RES_W'(-o9_res_ff[c]) : o9_res_ff[c];
         scaled[c] = ZW'(resmag[c]) << o9_k_ff;
         if (scaled[c] > ZW'(zero_limit)) begin
            o10_small_in = 1'b0;
         end
      end
      xzm = x10[2][UNIT_W-1] ? -x10[2] : x10[2];
      if (!o10_small_ff) begin
         o11_vec_in = o10_res_ff;
      end else if (o10_nearz_ff) begin
         o11_vec_in[0] = '0;
         o11_vec_in[1] = -RES_W'($signed(x11[2]));
         o11_vec_in[2] = RES_W'($signed(x11[1]));
      end else begin
         o11_vec_in[0] = -RES_W'($signed(x11[1]));
         o11_vec_in[1] = RES_W'($signed(x11[0]));
         o11_vec_in[2] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dl_ff     <= {dl_ff[LAT-2:0], {in_side, in_x}};
         o1_bm_ff  <= o1_bm_in;
         o1_neg_ff <= {in_b[2][CW-1], in_b[1][CW-1], in_b[0][CW-1]};
         o2_bm_ff  <= o1_bm_ff;
         o2_neg_ff <= o1_neg_ff;
         o2_k_ff   <= o2_k_in;
         o3_sb_ff  <= o3_sb_in;
         o3_k_ff   <= o2_k_ff;
         for (int c = 0; c < 3; c++) begin
            o4_prod_ff[c] <= $signed(o3_sb_ff[c]) * $signed(x4[c]);
         end
         o4_sb_ff  <= o3_sb_ff;
         o4_k_ff   <= o3_k_ff;
         o5_dot_ff <= 67'($signed(o4_prod_ff[0])) + 67'($signed(o4_prod_ff[1]))
                    + 67'($signed(o4_prod_ff[2]));
         o5_sb_ff  <= o4_sb_ff;
         o5_k_ff   <= o4_k_ff;
         o6_d_ff   <= 34'(rnd30(68'($signed(o5_dot_ff))));
         o6_sb_ff  <= o5_sb_ff;
         o6_k_ff   <= o5_k_ff;
         for (int c = 0; c < 3; c++) begin
            o7_dx_ff[c] <= $signed(o6_d_ff) * $signed(x7[c]);
            o8_rx_ff[c] <= 34'(rnd30(68'($signed(o7_dx_ff[c]))));
            o9_res_ff[c] <= RES_W'($signed(o8_sb_ff[c])) - RES_W'($signed(o8_rx_ff[c]));
         end
         o7_sb_ff     <= o6_sb_ff;
         o7_k_ff      <= o6_k_ff;
         o8_sb_ff     <= o7_sb_ff;
         o8_k_ff      <= o7_k_ff;
         o9_k_ff      <= o8_k_ff;
         o10_res_ff   <= o9_res_ff;
         o10_small_ff <= o10_small_in;
         o10_nearz_ff <= (xzm >= NINE_TENTHS_Q30);
         o11_vec_ff   <= o11_vec_in;
      end
   end

   assign out_valid = v_ff[LAT-1];
   assign out_vec   = o11_vec_ff;
   assign out_x     = dl_ff[LAT-1][XW-1:0];
   assign out_side  = dl_ff[LAT-1][DW-1:XW];

endmodule

// ===== rtl/core/fon_cross.sv =====
`timescale 1ns / 1ps

module fon_cross #(
   parameter int SW = 96
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 en,
   input  logic                                 in_valid,
   input  logic [2:0][fon_pkg::UNIT_W-1:0]      in_x,
   input  logic [2:0][fon_pkg::UNIT_W-1:0]      in_y,
   input  logic [SW-1:0]                        in_side,
   output logic                                 out_valid,
   output logic [2:0][fon_pkg::UNIT_W-1:0]      out_x,
   output logic [2:0][fon_pkg::UNIT_W-1:0]      out_y,
   output logic [2:0][fon_pkg::UNIT_W-1:0]      out_z,
   output logic [SW-1:0]                        out_side
);
   import fon_pkg::*;

   localparam int XW  = 3 * UNIT_W;
   localparam int DW  = 2 * XW + SW;
   localparam int LAT = 4;

   logic [LAT-1:0]         v_ff;
   logic [LAT-1:0][DW-1:0] dl_ff;
   logic [5:0][63:0]       c1_prod_ff;
   logic [2:0][64:0]       c2_diff_ff;
   logic [2:0][32:0]       c3_rn_ff;
   logic [2:0][UNIT_W-1:0] c4_z_in, c4_z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[LAT-2:0], in_valid};
      end
   end

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         if ($signed(c3_rn_ff[c]) > $signed(33'(ONE_Q30))) begin
            c4_z_in[c] = ONE_Q30;
         end else if ($signed(c3_rn_ff[c]) < -$signed(33'(ONE_Q30))) begin
            c4_z_in[c] = -ONE_Q30;
         end else begin
            c4_z_in[c] = c3_rn_ff[c][UNIT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dl_ff         <= {dl_ff[LAT-2:0], {in_side, in_y, in_x}};
         c1_prod_ff[0] <= $signed(in_x[1]) * $signed(in_y[2]);
         c1_prod_ff[1] <= $signed(in_x[2]) * $signed(in_y[1]);
         c1_prod_ff[2] <= $signed(in_x[2]) * $signed(in_y[0]);
         c1_prod_ff[3] <= $signed(in_x[0]) * $signed(in_y[2]);
         c1_prod_ff[4] <= $signed(in_x[0]) * $signed(in_y[1]);
         c1_prod_ff[5] <= $signed(in_x[1]) * $signed(in_y[0]);
         for (int c = 0; c < 3; c++) begin
            c2_diff_ff[c] <= 65'($signed(c1_prod_ff[2*c])) - 65'($signed(c1_prod_ff[2*c+1]));
            c3_rn_ff[c]   <= 33'(rnd30(68'($signed(c2_diff_ff[c]))));
         end
         c4_z_ff <= c4_z_in;
      end
   end

   assign out_valid = v_ff[LAT-1];
   assign out_x     = dl_ff[LAT-1][XW-1:0];
   assign out_y     = dl_ff[LAT-1][2*XW-1:XW];
   assign out_z     = c4_z_ff;
   assign out_side  = dl_ff[LAT-1][DW-1:2*XW];

endmodule

// ===== rtl/core/frame_orthonormalize_3d_core.sv =====
`timescale 1ns / 1ps

// Turns a frame (base point plus requested X and Y directions, Q16.16) into the orthonormal
// right-handed 3x4 frame-to-world block: unit X, Gram-Schmidt unit Y, Z = X cross Y, all Q1.30,
// and the base point passed through. One request is taken per clock cycle while req_tready is
// high; each result passes through the input register, 68-stage unit-length pipeline for X,
// 11-stage Gram-Schmidt pipeline, 68-stage unit-length pipeline for Y, 4-stage cross product,
// output register. Each unit-length pipeline holds a 31-stage square root and a 31-stage
// three-lane divider, one result bit per stage. While a result waits in the output register,
// the pipeline keeps advancing and taking requests only as long as the last stage before the
// output register holds no result; once the next result arrives there, the whole pipeline and
// req_tready hold until the waiting result is taken. zero_limit is written through
// csr_wr_en/csr_wr_data and should change only while no request is in flight.
module frame_orthonormalize_3d_core #(
   parameter int COORD_WIDTH = 32
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_wr_en,
   input  logic [fon_pkg::CSR_W-1:0]              csr_wr_data,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // base_point_x/y/z, first_axis_in_x/y/z, second_axis_in_x/y/z
   input  logic [((9*COORD_WIDTH+7)/8)*8-1:0]     req_tdata,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // unit_first_x/y/z, unit_second_x/y/z, unit_third_x/y/z, shift_out_x/y/z
   output logic [((9*fon_pkg::UNIT_W+3*COORD_WIDTH+7)/8)*8-1:0] rsp_tdata
);
   import fon_pkg::*;

   localparam int CW     = COORD_WIDTH;
   localparam int XW     = 3 * UNIT_W;
   localparam int PW     = 3 * CW;
   localparam int OUT_W  = 9 * UNIT_W + PW;
   localparam int OUT_TW = ((OUT_W + 7) / 8) * 8;

   logic                   en, take;
   logic [CSR_W-1:0]       zero_limit_ff;
   logic [2:0][CW-1:0]     req_a, req_b, req_bp, am;
   logic                   small_in;
   logic                   s0_valid_ff;
   logic [2:0][CW-1:0]     s0_a_ff, s0_b_ff, s0_bp_ff;

   logic                   nx_valid;
   logic [2:0][UNIT_W-1:0] nx_vec;
   logic [2*PW-1:0]        nx_side;
   logic                   og_valid;
   logic [2:0][RES_W-1:0]  og_vec;
   logic [2:0][UNIT_W-1:0] og_x;
   logic [PW-1:0]          og_side;
   logic                   ny_valid;
   logic [2:0][UNIT_W-1:0] ny_vec;
   logic [XW+PW-1:0]       ny_side;
   logic                   cr_valid;
   logic [2:0][UNIT_W-1:0] cr_x, cr_y, cr_z;
   logic [PW-1:0]          cr_side;

   logic                   rsp_valid_ff;
   logic [OUT_TW-1:0]      rsp_data_ff;

   assign take       = !rsp_valid_ff || rsp_tready;
   assign en         = take || !cr_valid;
   assign req_tready = en;

   always_comb begin
      small_in = 1'b1;
      for (int c = 0; c < 3; c++) begin
         req_bp[c] = req_tdata[c*CW +: CW];
         req_a[c]  = req_tdata[(3+c)*CW +: CW];
         req_b[c]  = req_tdata[(6+c)*CW +: CW];
         am[c]     = req_a[c][CW-1] ? -req_a[c] : req_a[c];
         if (am[c] > CW'(zero_limit_ff)) begin
            small_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         zero_limit_ff <= '0;
         s0_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            zero_limit_ff <= csr_wr_data;
         end
         if (en) begin
            s0_valid_ff <= req_tvalid;
         end
         if (take) begin
            rsp_valid_ff <= cr_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s0_a_ff  <= small_in ? '0 : req_a;
         s0_b_ff  <= req_b;
         s0_bp_ff <= req_bp;
      end
      if (take) begin
         rsp_data_ff <= OUT_TW'({cr_side, cr_z, cr_y, cr_x});
      end
   end

   fon_norm #(.VW(CW), .SW(2 * PW)) u_norm_x (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s0_valid_ff),
      .in_vec    (s0_a_ff),
      .in_side   ({s0_bp_ff, s0_b_ff}),
      .out_valid (nx_valid),
      .out_vec   (nx_vec),
      .out_side  (nx_side)
   );

   fon_ortho #(.CW(CW), .SW(PW)) u_ortho (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .zero_limit (zero_limit_ff),
      .in_valid   (nx_valid),
      .in_x       (nx_vec),
      .in_b       (nx_side[PW-1:0]),
      .in_side    (nx_side[2*PW-1:PW]),
      .out_valid  (og_valid),
      .out_vec    (og_vec),
      .out_x      (og_x),
      .out_side   (og_side)
   );

   fon_norm #(.VW(RES_W), .SW(XW + PW)) u_norm_y (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (og_valid),
      .in_vec    (og_vec),
      .in_side   ({og_side, og_x}),
      .out_valid (ny_valid),
      .out_vec   (ny_vec),
      .out_side  (ny_side)
   );

   fon_cross #(.SW(PW)) u_cross (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (ny_valid),
      .in_x      (ny_side[XW-1:0]),
      .in_y      (ny_vec),
      .in_side   (ny_side[XW+PW-1:XW]),
      .out_valid (cr_valid),
      .out_x     (cr_x),
      .out_y     (cr_y),
      .out_z     (cr_z),
      .out_side  (cr_side)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== rtl/core/fon_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fon_checker #(
   parameter int COORD_WIDTH = 32
) (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   req_tvalid,
   input logic                                   req_tready,
   input logic                                   rsp_tvalid,
   input logic                                   rsp_tready,
   input logic [((9*fon_pkg::UNIT_W+3*COORD_WIDTH+7)/8)*8-1:0] rsp_tdata
);

   logic               stalled;
   logic signed [31:0] first_x;
   logic               first_x_ok;

   assign stalled    = rsp_tvalid && !rsp_tready;
   assign first_x    = rsp_tdata[31:0];
   assign first_x_ok = (first_x <= 32'sd1073741824) && (first_x >= -32'sd1073741824);

   `FON_ASSERT_IMPLY(a_ready_when_empty, clock, reset, !rsp_tvalid, req_tready)
   `FON_ASSERT_NEXT(a_hold_stalled, clock, reset, stalled, rsp_tvalid && $stable(rsp_tdata))
   `FON_ASSERT_NEXT(a_quiet_after_reset, clock, 1'b0, reset, !rsp_tvalid)
   `FON_ASSERT_IMPLY(a_unit_range, clock, reset, rsp_tvalid, first_x_ok)

endmodule

bind frame_orthonormalize_3d_core fon_checker #(.COORD_WIDTH(COORD_WIDTH)) u_fon_checker (.*);

// ===== tb/sv/frame_orthonormalize_3d_core_tb.sv =====
`timescale 1ns / 1ps

module frame_orthonormalize_3d_core_tb;

   localparam int CW = 32;
   localparam int REQ_W = ((9*CW+7)/8)*8;
   localparam int RSP_W = ((9*fon_pkg::UNIT_W+3*CW+7)/8)*8;
   localparam longint ONE = 64'sd1 << 30;
   localparam longint NINE_TENTHS = 64'sd966367642;
   localparam int LATENCY = 153;
   localparam longint CYCLE_LIMIT = 2000000;

   logic clock = 0;
   logic reset = 1;
   logic csr_wr_en = 0;
   logic [fon_pkg::CSR_W-1:0] csr_wr_data = '0;
   logic req_tvalid = 0;
   logic req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [RSP_W-1:0] rsp_tdata;

   int errors = 0;
   longint cycles = 0;
   bit rsp_idle_off = 0;
   bit hold_rsp = 0;

   frame_orthonormalize_3d_core #(.COORD_WIDTH(CW)) dut (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   function automatic longint unsigned magn(longint v);
      return v < 0 ? -v : v;
   endfunction

   function automatic longint round30(longint v);
      longint unsigned u;
      u = (magn(v) + (64'd1 << 29)) >> 30;
      return v < 0 ? -longint'(u) : longint'(u);
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned s);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > s) bitv >>= 2;
      while (bitv != 0) begin
         if (s >= res + bitv) begin
            s -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic void normalize(input longint v[3], output longint o[3]);
      longint unsigned m[3], mx, s, r;
      mx = 0;
      s = 0;
      for (int i = 0; i < 3; i++) begin
         m[i] = magn(v[i]);
         if (m[i] > mx) mx = m[i];
      end
      if (mx == 0) begin
         o[0] = ONE; o[1] = 0; o[2] = 0;
         return;
      end
      while (mx >= (64'd1 << 30)) begin
         for (int i = 0; i < 3; i++) m[i] >>= 1;
         mx >>= 1;
      end
      while (mx < (64'd1 << 29)) begin
         for (int i = 0; i < 3; i++) m[i] <<= 1;
         mx <<= 1;
      end
      for (int i = 0; i < 3; i++) s += m[i] * m[i];
      r = int_sqrt(s);
      for (int i = 0; i < 3; i++) begin
         o[i] = longint'((2 * (m[i] << 30) + r) / (2 * r));
         if (v[i] < 0) o[i] = -o[i];
      end
   endfunction

   function automatic longint clamp1(longint v);
      if (v > ONE) return ONE;
      if (v < -ONE) return -ONE;
      return v;
   endfunction

   function automatic logic [RSP_W-1:0] frame_matrix(logic [REQ_W-1:0] d,
                                                     longint unsigned lim);
      longint bp[3], a[3], b[3], x[3], y[3], res[3], t[3], z[3], dot, dd;
      longint unsigned bm[3], mx, m;
      int k;
      bit tiny;
      logic [RSP_W-1:0] o;
      mx = 0;
      k = 0;
      o = '0;
      for (int i = 0; i < 3; i++) begin
         bp[i] = $signed(d[i*CW +: CW]);
         a[i] = $signed(d[(3+i)*CW +: CW]);
         b[i] = $signed(d[(6+i)*CW +: CW]);
      end
      tiny = 1;
      for (int i = 0; i < 3; i++) if (magn(a[i]) > lim) tiny = 0;
      if (tiny) begin
         x[0] = ONE; x[1] = 0; x[2] = 0;
      end else begin
         normalize(a, x);
      end
      for (int i = 0; i < 3; i++) begin
         bm[i] = magn(b[i]);
         if (bm[i] > mx) mx = bm[i];
      end
      while (mx > (64'd1 << 31)) begin
         for (int i = 0; i < 3; i++) bm[i] >>= 1;
         mx >>= 1;
         k++;
      end
      for (int i = 0; i < 3; i++) b[i] = b[i] < 0 ? -longint'(bm[i]) : longint'(bm[i]);
      dot = b[0]*x[0] + b[1]*x[1] + b[2]*x[2];
      dd = round30(dot);
      tiny = 1;
      for (int i = 0; i < 3; i++) begin
         res[i] = b[i] - round30(dd * x[i]);
         m = magn(res[i]);
         if (m > lim || (m << k) > lim) tiny = 0;
      end
      if (tiny) begin
         if (magn(x[2]) < NINE_TENTHS) begin
            t[0] = -x[1]; t[1] = x[0]; t[2] = 0;
         end else begin
            t[0] = 0; t[1] = -x[2]; t[2] = x[1];
         end
         normalize(t, y);
      end else begin
         normalize(res, y);
      end
      z[0] = clamp1(round30(x[1]*y[2] - x[2]*y[1]));
      z[1] = clamp1(round30(x[2]*y[0] - x[0]*y[2]));
      z[2] = clamp1(round30(x[0]*y[1] - x[1]*y[0]));
      for (int i = 0; i < 3; i++) begin
         o[i*32 +: 32] = x[i][31:0];
         o[(3+i)*32 +: 32] = y[i][31:0];
         o[(6+i)*32 +: 32] = z[i][31:0];
         o[288 + i*CW +: CW] = bp[i][CW-1:0];
      end
      return o;
   endfunction

   class frame_scoreboard;
      logic [RSP_W-1:0] pending[$];
      longint unsigned zero_lim;

      function void note_request(logic [REQ_W-1:0] d);
         pending.push_back(frame_matrix(d, zero_lim));
      endfunction

      function void check_result(logic [RSP_W-1:0] got);
         logic [RSP_W-1:0] want;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result %h", $time, got);
            errors++;
            return;
         end
         want = pending.pop_front();
         for (int f = 0; f < 12; f++)
            if (want[f*32 +: 32] !== got[f*32 +: 32]) begin
               $display("%0t: field %0d expected %h actual %h", $time, f,
                        want[f*32 +: 32], got[f*32 +: 32]);
               errors++;
            end
      endfunction
   endclass

   frame_scoreboard frames = new();

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) frames.check_result(rsp_tdata);
      if (!reset && req_tvalid && req_tready) frames.note_request(req_tdata);
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("frame_orthonormalize_3d_core test failed");
         $finish;
      end
   end

   initial begin : rsp_side
      int n;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_tready <= 0;
            repeat (400) @(posedge clock);
            hold_rsp = 0;
         end else if (!rsp_idle_off && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 12);
            rsp_tready <= 0;
            repeat (n) @(posedge clock);
         end else begin
            rsp_tready <= 1;
            @(posedge clock);
         end
      end
   end

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return $urandom_range(0, 8) - 4;
         3: return $signed($urandom_range(0, 1 << 20)) - (1 << 19);
         default: return $urandom;
      endcase
   endfunction

   task automatic send_frame(logic [REQ_W-1:0] d, bit gaps);
      if (gaps && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= d;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic send_random(bit gaps);
      logic [REQ_W-1:0] d;
      logic [31:0] s;
      d = '0;
      for (int i = 0; i < 9; i++) d[i*32 +: 32] = rand_coord();
      case ($urandom_range(0, 4))
         0: begin
            s = $urandom_range(0, 7) - 3;
            for (int i = 0; i < 3; i++)
               d[(6+i)*32 +: 32] = d[(3+i)*32 +: 32] * s + ($urandom_range(0, 2) - 1);
         end
         1: for (int i = 0; i < 3; i++) d[(3+i)*32 +: 32] = $urandom_range(0, 8) - 4;
         default: ;
      endcase
      send_frame(d, gaps);
   endtask

   task automatic drain();
      req_tvalid <= 0;
      @(posedge clock);
      while (frames.pending.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   task automatic write_limit(logic [15:0] v);
      csr_wr_en <= 1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 0;
      frames.zero_lim = v;
      @(posedge clock);
   endtask

   initial begin : req_side
      logic [REQ_W-1:0] d;
      logic [15:0] limits[4];
      limits = '{16'd0, 16'hffff, 16'd5, 16'd300};
      frames.zero_lim = 0;
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      d = '0;
      send_frame(d, 0);
      d[3*32 +: 32] = 32'h0001_0000; d[7*32 +: 32] = 32'h0001_0000;
      send_frame(d, 0);
      d = {32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
           32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff};
      send_frame(d, 0);
      d = '0; d[5*32 +: 32] = 32'h0001_0000; d[8*32 +: 32] = 32'h0002_0000;
      send_frame(d, 0);
      d = '0; d[3*32 +: 32] = 32'h0001_0000; d[6*32 +: 32] = 32'hffff_0000;
      send_frame(d, 0);
      d = '0; d[3*32 +: 32] = 32'h0000_1000; d[5*32 +: 32] = 32'h0001_0000;
      d[6*32 +: 32] = 32'h0000_1000; d[8*32 +: 32] = 32'h0001_0000;
      send_frame(d, 0);
      d = '0; d[4*32 +: 32] = 32'hffff_ffff; d[8*32 +: 32] = 32'h8000_0000;
      send_frame(d, 0);
      d = '1;
      send_frame(d, 0);

      hold_rsp = 1;
      for (int i = 0; i < 300; i++) send_random(0);

      for (int p = 0; p < 4; p++) begin
         drain();
         write_limit(limits[p]);
         d = '0; d[3*32 +: 32] = limits[p]; d[7*32 +: 32] = 32'h0001_0000;
         send_frame(d, 0);
         for (int i = 0; i < 250; i++) send_random(p < 3);
         if (p == 2) rsp_idle_off = 1;
      end
      drain();
      write_limit(16'($urandom));
      for (int i = 0; i < 10; i++) send_random(0);
      drain();

      if (errors == 0) begin
         $display("frame_orthonormalize_3d_core test passed");
      end else begin
         $display("frame_orthonormalize_3d_core test failed");
      end
      $finish;
   end

endmodule
